### src/lzsd_pkg.sv
// Shared constants, result beat type and helpers for the LZ window sprite decompressor.
package lzsd_pkg;

    localparam int HISTORY_DEPTH_DEF = 2048;

    localparam int BYTE_W      = 8;
    localparam int SIZE_W      = 16;
    localparam int CNT_W       = 17;
    localparam int OFS_W       = 11;
    localparam int IN_TDATA_W  = 24;   // in_byte + sprite_size
    localparam int OUT_TDATA_W = 32;   // out_byte + sprite_done + bytes_consumed, padded

    localparam logic [CNT_W-1:0]  CNT_MAX      = {CNT_W{1'b1}};
    localparam logic [3:0]        HDR_LEN      = 4'd8;
    localparam logic [BYTE_W-1:0] RUN_ZERO_LEN = 8'd128;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
        logic              sprite_done;
        logic [CNT_W-1:0]  bytes_consumed;
        logic              status;
    } out_item_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v != CNT_MAX) ? v + 1'b1 : CNT_MAX;
    endfunction

endpackage

### src/lz_window_sprite_decompressor.sv
// LZ window sprite decompressor: stream parser, history read/modify/write and output beats.
// Header and literal bytes: beat accepted, result loaded into the output register from
// ENG_EMIT once it is free, with no new byte taken meanwhile. Control bytes and idle
// bytes are taken with no result. Back copies: the offset byte is accepted, then each
// copied byte takes a history read, then a write back and emit, in the single history memory.
// Reset (rst_n, asynchronous, active low) clears control state and counters; the history
// memory is not cleared, a copy only reads bytes written earlier in the same sprite.
module lz_window_sprite_decompressor
    import lzsd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // in_byte, sprite_size
    input  logic                   s_axis_tuser,   // first_byte
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_byte, sprite_done, bytes_consumed
    output logic                   m_axis_tlast,   // run_last
    output logic                   m_axis_tuser    // status
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW-1:0] WP_LAST   = AW'(HISTORY_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(HISTORY_DEPTH);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_CONTROL = 3'd2;
    localparam logic [2:0] PH_LITERAL = 3'd3;
    localparam logic [2:0] PH_COPY    = 3'd4;

    localparam logic [2:0] ENG_ACCEPT = 3'd0;
    localparam logic [2:0] ENG_EMIT   = 3'd1;
    localparam logic [2:0] ENG_CRD    = 3'd2;
    localparam logic [2:0] ENG_CWR    = 3'd3;
    localparam logic [2:0] ENG_ERR    = 3'd4;

    logic [2:0]        eng_reg, eng_next;
    logic [2:0]        phase_reg, phase_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [CNT_W-1:0]  prod_reg, prod_next;
    logic [CNT_W-1:0]  cons_reg, cons_next;
    logic [SIZE_W-1:0] target_reg, target_next;
    logic              cc_reg, cc_next;
    logic [7:0]        lit_left_reg, lit_left_next;
    logic [7:0]        code_reg, code_next;
    logic [3:0]        hdr_left_reg, hdr_left_next;
    logic              last_chk_reg, last_chk_next;
    logic [4:0]        copy_left_reg, copy_left_next;
    logic [AW-1:0]     src_reg, src_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;

    logic              accept;
    logic [BYTE_W-1:0] in_byte;
    logic [SIZE_W-1:0] sprite_size;
    logic [CNT_W-1:0]  prod_inc;
    logic [CNT_W-1:0]  cons_inc;
    logic              end_hit;
    logic [OFS_W-1:0]  offset;
    logic [AW:0]       src_calc;
    logic [3:0]        hdr_dec;
    logic [7:0]        lit_dec;
    logic              copy_last;

    logic              ram_we;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;

    logic              out_load;
    logic              out_free;
    out_item_t         out_item;

    assign s_axis_tready = (eng_reg == ENG_ACCEPT);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_byte       = s_axis_tdata[7:0];
    assign sprite_size   = s_axis_tdata[23:8];

    assign prod_inc  = sat_inc(prod_reg);
    assign cons_inc  = sat_inc(cons_reg);
    // size check as made before the next control byte, with this byte counted
    assign end_hit   = (cc_reg ? cons_reg : prod_inc) >= {1'b0, target_reg};
    assign offset    = {code_reg[2:0], in_byte};
    assign src_calc  = ({1'b0, wp_reg} >= (AW+1)'(offset))
                     ? {1'b0, wp_reg} - (AW+1)'(offset)
                     : {1'b0, wp_reg} + DEPTH_EXT - (AW+1)'(offset);
    assign hdr_dec   = (hdr_left_reg != 4'd0) ? hdr_left_reg - 4'd1 : 4'd0;
    assign lit_dec   = (lit_left_reg != 8'd0) ? lit_left_reg - 8'd1 : 8'd0;
    assign copy_last = (copy_left_reg == 5'd1);

    always_comb
    begin
        eng_next       = eng_reg;
        phase_next     = phase_reg;
        wp_next        = wp_reg;
        prod_next      = prod_reg;
        cons_next      = cons_reg;
        target_next    = target_reg;
        cc_next        = cc_reg;
        lit_left_next  = lit_left_reg;
        code_next      = code_reg;
        hdr_left_next  = hdr_left_reg;
        last_chk_next  = last_chk_reg;
        copy_left_next = copy_left_reg;
        src_next       = src_reg;
        byte_next      = byte_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_wdata      = byte_reg;
        out_load       = 1'b0;
        out_item       = '0;

        case (eng_reg)
            ENG_ACCEPT:
            begin
                if (accept)
                begin
                    if (s_axis_tuser)
                    begin
                        target_next   = sprite_size;
                        cc_next       = in_byte[1];
                        prod_next     = '0;
                        cons_next     = CNT_W'(1);
                        hdr_left_next = HDR_LEN - 4'd1;
                        lit_left_next = '0;
                        code_next     = '0;
                        phase_next    = PH_HEADER;
                        byte_next     = in_byte;
                        last_chk_next = 1'b0;
                        eng_next      = ENG_EMIT;
                    end
                    else if (phase_reg != PH_IDLE)
                    begin
                        cons_next = cons_inc;
                        case (phase_reg)
                            PH_HEADER:
                            begin
                                byte_next     = in_byte;
                                hdr_left_next = hdr_dec;
                                last_chk_next = (hdr_dec == 4'd0);
                                eng_next      = ENG_EMIT;
                            end
                            PH_CONTROL:
                            begin
                                if (in_byte[7])
                                begin
                                    code_next  = in_byte;
                                    phase_next = PH_COPY;
                                end
                                else
                                begin
                                    lit_left_next = (in_byte == 8'd0) ? RUN_ZERO_LEN : in_byte;
                                    phase_next    = PH_LITERAL;
                                end
                            end
                            PH_LITERAL:
                            begin
                                byte_next     = in_byte;
                                lit_left_next = lit_dec;
                                last_chk_next = (lit_dec == 8'd0);
                                eng_next      = ENG_EMIT;
                            end
                            PH_COPY:
                            begin
                                copy_left_next = 5'(6'd32 - {1'b0, code_reg[7:3]});
                                if ((offset == '0) || ({6'd0, offset} > prod_reg))
                                begin
                                    phase_next = PH_IDLE;
                                    eng_next   = ENG_ERR;
                                end
                                else
                                begin
                                    src_next = src_calc[AW-1:0];
                                    eng_next = ENG_CRD;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            ENG_EMIT:
            begin
                if (out_free)
                begin
                    ram_we                  = 1'b1;
                    out_load                = 1'b1;
                    out_item.out_byte       = byte_reg;
                    out_item.run_last       = 1'b1;
                    out_item.sprite_done    = last_chk_reg && end_hit;
                    out_item.bytes_consumed = cons_reg;
                    wp_next                 = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
                    prod_next               = prod_inc;
                    if (last_chk_reg)
                    begin
                        phase_next = end_hit ? PH_IDLE : PH_CONTROL;
                    end
                    eng_next = ENG_ACCEPT;
                end
            end
            ENG_CRD:
            begin
                ram_re   = 1'b1;
                eng_next = ENG_CWR;
            end
            ENG_CWR:
            begin
                // write lands before the next read, so short offsets see fresh bytes
                if (out_free)
                begin
                    ram_we                  = 1'b1;
                    ram_wdata               = ram_rdata;
                    out_load                = 1'b1;
                    out_item.out_byte       = ram_rdata;
                    out_item.run_last       = copy_last;
                    out_item.sprite_done    = copy_last && end_hit;
                    out_item.bytes_consumed = cons_reg;
                    wp_next                 = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;
                    src_next                = (src_reg == WP_LAST) ? '0 : src_reg + 1'b1;
                    prod_next               = prod_inc;
                    copy_left_next          = copy_left_reg - 5'd1;
                    if (copy_last)
                    begin
                        phase_next = end_hit ? PH_IDLE : PH_CONTROL;
                        eng_next   = ENG_ACCEPT;
                    end
                    else
                    begin
                        eng_next = ENG_CRD;
                    end
                end
            end
            ENG_ERR:
            begin
                if (out_free)
                begin
                    out_load                = 1'b1;
                    out_item.run_last       = 1'b1;
                    out_item.bytes_consumed = cons_reg;
                    out_item.status         = 1'b1;
                    eng_next                = ENG_ACCEPT;
                end
            end
            default:
            begin
                eng_next = ENG_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_reg       <= ENG_ACCEPT;
            phase_reg     <= PH_IDLE;
            wp_reg        <= '0;
            prod_reg      <= '0;
            cons_reg      <= '0;
            target_reg    <= '0;
            cc_reg        <= 1'b0;
            lit_left_reg  <= '0;
            code_reg      <= '0;
            hdr_left_reg  <= '0;
            last_chk_reg  <= 1'b0;
            copy_left_reg <= '0;
        end
        else
        begin
            eng_reg       <= eng_next;
            phase_reg     <= phase_next;
            wp_reg        <= wp_next;
            prod_reg      <= prod_next;
            cons_reg      <= cons_next;
            target_reg    <= target_next;
            cc_reg        <= cc_next;
            lit_left_reg  <= lit_left_next;
            code_reg      <= code_next;
            hdr_left_reg  <= hdr_left_next;
            last_chk_reg  <= last_chk_next;
            copy_left_reg <= copy_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg  <= src_next;
        byte_reg <= byte_next;
    end

    lzsd_hist_ram #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (src_reg),
        .rdata (ram_rdata)
    );

    lzsd_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .item          (out_item),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### src/lzsd_hist_ram.sv
// History window memory: one write port, one registered read port.
module lzsd_hist_ram
    import lzsd_pkg::*;
#(
    parameter int DEPTH = HISTORY_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/lzsd_out_reg.sv
// Output holding register for result beats, packs the stream fields.
module lzsd_out_reg
    import lzsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  out_item_t              item,
    output logic                   free,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_byte, sprite_done, bytes_consumed
    output logic                   m_axis_tlast,   // run_last
    output logic                   m_axis_tuser    // status
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {6'd0, item_reg.bytes_consumed, item_reg.sprite_done,
                            item_reg.out_byte};
    assign m_axis_tlast  = item_reg.run_last;
    assign m_axis_tuser  = item_reg.status;

endmodule

### src/lzsd_checker.sv
// Port-level checks for the LZ window sprite decompressor, bound to the top level.
module lzsd_checker
    import lzsd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast,
    input logic                   m_axis_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // an abort beat is a lone, final beat with a zero byte and no sprite end
    a_abort_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[8:0] == 9'd0))
        else $error("abort beat malformed");

    // sprite end only on the last beat of a step
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tlast && !m_axis_tuser)
        else $error("sprite_done off the last beat");

    // the first header byte always yields a result before the next beat is taken
    a_first_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("input taken while first header byte pending");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

endmodule

bind lz_window_sprite_decompressor lzsd_checker u_lzsd_checker (.*);

### bench/lz_window_sprite_decompressor_tb.sv
// Self-checking bench for the LZ window sprite decompressor: stream stimulus and scoreboard.
`timescale 1ns / 100ps

module lz_window_sprite_decompressor_tb;
    import lzsd_pkg::*;

    localparam int ITEM_GOAL        = 320;
    localparam int CALM_FROM        = 270;
    localparam int LONG_HOLD_AT     = 120;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 40;      // longest copy is 16 bytes
    localparam int DRAIN_LIMIT      = 200000;
    localparam int REPORT_MAX       = 10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEADER,
        ST_CONTROL,
        ST_LITERAL,
        ST_COPY
    } dec_state_t;

    // Tracks decoder state and holds the beats still owed by the block.
    class sprite_scoreboard;
        out_item_t        expected_beats[$];
        out_item_t        run[$];
        logic [7:0]       hist [HISTORY_DEPTH_DEF];
        logic [OFS_W-1:0] wr_ptr;
        logic [CNT_W-1:0] produced;
        logic [CNT_W-1:0] consumed;
        logic [SIZE_W-1:0] target;
        logic             by_consumed;
        dec_state_t       phase;
        logic [7:0]       lit_left;
        logic [7:0]       copy_code;
        logic [3:0]       hdr_left;
        int unsigned      errors;
        int unsigned      reported;
        int unsigned      checked;
        int unsigned      ended;
        int unsigned      aborted;

        function new();
            wr_ptr      = '0;
            produced    = '0;
            consumed    = '0;
            target      = '0;
            by_consumed = 1'b0;
            phase       = ST_IDLE;
            lit_left    = '0;
            copy_code   = '0;
            hdr_left    = '0;
            errors      = 0;
            reported    = 0;
            checked     = 0;
            ended       = 0;
            aborted     = 0;
        endfunction

        function logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
            return (v == CNT_MAX) ? v : v + 1'b1;
        endfunction

        function void put(input logic [7:0] v);
            out_item_t r;
            r = '0;
            r.out_byte = v;
            hist[wr_ptr] = v;
            wr_ptr++;
            produced = bump(produced);
            run.push_back(r);
        endfunction

        // size check, made only where a control byte would come next
        function logic size_reached();
            logic [CNT_W-1:0] c;
            c = by_consumed ? consumed : produced;
            if (c >= {1'b0, target}) begin
                phase = ST_IDLE;
                return 1'b1;
            end
            phase = ST_CONTROL;
            return 1'b0;
        endfunction

        // Returns 0 when the byte is ignored (no sprite under way).
        function bit accept_byte(input logic [7:0] b, input logic first,
                                 input logic [SIZE_W-1:0] size);
            logic             done;
            logic             bad;
            int unsigned      len;
            logic [OFS_W-1:0] ofs;
            logic [OFS_W-1:0] src;
            out_item_t        r;
            done = 1'b0;
            bad  = 1'b0;
            run.delete();
            if (first) begin
                target      = size;
                by_consumed = b[1];
                produced    = '0;
                consumed    = CNT_W'(1);
                hdr_left    = HDR_LEN - 4'd1;
                lit_left    = '0;
                copy_code   = '0;
                phase       = ST_HEADER;
                put(b);
            end
            else if (phase == ST_IDLE) begin
                return 1'b0;
            end
            else begin
                consumed = bump(consumed);
                case (phase)
                    ST_HEADER:
                    begin
                        put(b);
                        if (hdr_left != 0)
                            hdr_left--;
                        if (hdr_left == 0)
                            done = size_reached();
                    end
                    ST_CONTROL:
                    begin
                        if (b[7]) begin
                            copy_code = b;
                            phase     = ST_COPY;
                        end
                        else begin
                            lit_left = (b == 8'd0) ? RUN_ZERO_LEN : b;
                            phase    = ST_LITERAL;
                        end
                    end
                    ST_LITERAL:
                    begin
                        put(b);
                        if (lit_left != 0)
                            lit_left--;
                        if (lit_left == 0)
                            done = size_reached();
                    end
                    default:
                    begin
                        // negative code: length is 32 - code[7:3], i.e. 1..16
                        len = 32 - int'(copy_code[7:3]);
                        ofs = {copy_code[2:0], b};
                        if (ofs == 0 || {6'b0, ofs} > produced) begin
                            bad   = 1'b1;
                            phase = ST_IDLE;
                        end
                        else begin
                            src = wr_ptr - ofs;
                            repeat (len) begin
                                put(hist[src]);
                                src++;
                            end
                            done = size_reached();
                        end
                    end
                endcase
            end

            if (bad) begin
                r = '0;
                r.run_last       = 1'b1;
                r.bytes_consumed = consumed;
                r.status         = 1'b1;
                expected_beats.push_back(r);
                aborted++;
                return 1'b1;
            end
            foreach (run[i]) begin
                run[i].bytes_consumed = consumed;
                if (i == run.size() - 1) begin
                    run[i].run_last    = 1'b1;
                    run[i].sprite_done = done;
                end
                expected_beats.push_back(run[i]);
            end
            if (done)
                ended++;
            return 1'b1;
        endfunction

        function void check_beat(input logic [OUT_TDATA_W-1:0] data, input logic last,
                                 input logic stat);
            out_item_t got;
            out_item_t want;
            got.out_byte       = data[7:0];
            got.sprite_done    = data[8];
            got.bytes_consumed = data[9 +: CNT_W];
            got.run_last       = last;
            got.status         = stat;
            checked++;
            if (expected_beats.size() == 0) begin
                errors++;
                if (reported < REPORT_MAX)
                    $display("unexpected beat: byte %02h last %b done %b consumed %0d status %b",
                             got.out_byte, got.run_last, got.sprite_done,
                             got.bytes_consumed, got.status);
                reported++;
            end
            else begin
                want = expected_beats.pop_front();
                if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
                    got.sprite_done !== want.sprite_done ||
                    got.bytes_consumed !== want.bytes_consumed ||
                    got.status !== want.status) begin
                    errors++;
                    if (reported < REPORT_MAX)
                        $display({"mismatch: exp byte %02h last %b done %b consumed %0d ",
                                  "status %b / got byte %02h last %b done %b consumed %0d ",
                                  "status %b"},
                                 want.out_byte, want.run_last, want.sprite_done,
                                 want.bytes_consumed, want.status,
                                 got.out_byte, got.run_last, got.sprite_done,
                                 got.bytes_consumed, got.status);
                    reported++;
                end
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;

    sprite_scoreboard sb;
    int unsigned      items_in;
    int unsigned      gap_pct;
    bit               calm;

    lz_window_sprite_decompressor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Called at a rising edge; returns at the edge where the beat was taken (or after a gap).
    task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] size);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {size, b};
        s_axis_tuser  <= first;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (sb.accept_byte(b, first, size))
            items_in++;
        calm = (items_in >= CALM_FROM);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // One sprite with random content, now and then with a bad offset; may be cut short by a restart.
    task automatic run_random_sprite();
        logic [7:0]       ctl;
        logic [7:0]       copy_lo;
        logic [7:0]       fb;
        logic [15:0]      target;
        logic [OFS_W-1:0] ofs;
        int unsigned      pick;
        int unsigned      len;
        int unsigned      reach;
        case ($urandom_range(0, 3))
            0, 1:    gap_pct = 0;
            2:       gap_pct = 10;
            default: gap_pct = 35;
        endcase
        fb   = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            target = 16'($urandom_range(0, 65535));
        else if (pick < 3)
            target = 16'($urandom_range(0, 8));
        else
            target = 16'($urandom_range(9, 70));
        copy_lo = '0;
        send_byte(fb, 1'b1, target);
        while (sb.phase != ST_IDLE && items_in < ITEM_GOAL && $urandom_range(0, 59) != 0)
        begin
            case (sb.phase)
                ST_CONTROL:
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 2)
                        ctl = 8'h00;
                    else if (pick < 45)
                        ctl = 8'($urandom_range(1, 8));
                    else if (pick < 50)
                        ctl = 8'($urandom_range(9, 127));
                    else begin
                        len   = $urandom_range(1, 16);
                        reach = (sb.produced > 2047) ? 2047 : int'(sb.produced);
                        if ($urandom_range(0, 24) == 0)
                            ofs = (reach == 2047 || $urandom_range(0, 1) == 0) ? 11'd0
                                  : 11'($urandom_range(reach + 1, 2047));
                        else if ($urandom_range(0, 1) == 0)
                            ofs = 11'($urandom_range(1, (reach < 20) ? reach : 20));
                        else
                            ofs = 11'($urandom_range(1, reach));
                        ctl     = {5'(32 - len), ofs[10:8]};
                        copy_lo = ofs[7:0];
                    end
                    send_byte(ctl, 1'b0, 16'($urandom_range(0, 65535)));
                end
                ST_COPY:
                    send_byte(copy_lo, 1'b0, 16'($urandom_range(0, 65535)));
                default:
                    send_byte(8'($urandom_range(0, 255)), 1'b0,
                              16'($urandom_range(0, 65535)));
            endcase
        end
    endtask

    // Output side: random stalls, quiet stretches, and one long hold to back the block up.
    initial
    begin
        int unsigned burst;
        int unsigned hold;
        int unsigned cyc;
        int unsigned sink_pct;
        bit          hold_done;
        burst     = 0;
        hold      = 0;
        cyc       = 0;
        sink_pct  = 0;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            cyc++;
            if (cyc % 128 == 0)
                case ($urandom_range(0, 3))
                    0:       sink_pct = 0;
                    1:       sink_pct = 10;
                    2:       sink_pct = 25;
                    default: sink_pct = 50;
                endcase
            if (!hold_done && items_in >= LONG_HOLD_AT) begin
                hold      = LONG_HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold != 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (burst != 0) begin
                burst--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < sink_pct) begin
                burst = $urandom_range(1, 6) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    initial
    begin
        #(5_000_000);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [7:0]  dir_seq [$];
        int unsigned waited;
        sb       = new();
        items_in = 0;
        gap_pct  = 0;
        calm     = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray byte with no sprite open: dropped
        send_byte(8'h5A, 1'b0, 16'hFFFF);
        // target below header length: ends on the last header byte
        send_byte(8'h00, 1'b1, 16'd3);
        for (int i = 1; i < 8; i++)
            send_byte(8'(i * 8'h11), 1'b0, 16'h0000);
        // header, 2 literals, 16-byte copy at offset 1 (overlapping), then an
        // offset far past the output so far, which aborts the sprite
        dir_seq = '{8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F,
                    8'h02, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h87, 8'hFF};
        send_byte(8'hFD, 1'b1, 16'd40);
        foreach (dir_seq[i])
            send_byte(dir_seq[i], 1'b0, 16'($urandom_range(0, 65535)));
        // sprite opened then abandoned by the next first byte
        send_byte(8'h02, 1'b1, 16'hFFFF);
        send_byte(8'h00, 1'b0, 16'h0000);

        while (items_in < ITEM_GOAL) begin
            while (sb.phase == ST_IDLE && $urandom_range(0, 2) == 0)
                send_byte(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)));
            run_random_sprite();
        end
        s_axis_tvalid <= 1'b0;

        waited = 0;
        while (sb.expected_beats.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        if (sb.expected_beats.size() != 0) begin
            $display("tb: failure");
            $finish;
        end
        else begin
            repeat (SETTLE_CYCLES)
                @(posedge clk);
            sb.errors += sb.expected_beats.size();
            $display("summary: %0d bytes decoded, %0d output beats checked, %0d errors",
                     items_in, sb.checked, sb.errors);
            $display("summary: %0d sprites hit their size target, %0d aborted on bad offsets",
                     sb.ended, sb.aborted);
            if (sb.errors == 0)
                $display("tb: success");
            else
                $display("tb: failure");
            $finish;
        end
    end

endmodule

### sim.f
src/lzsd_pkg.sv
src/lzsd_hist_ram.sv
src/lzsd_out_reg.sv
src/lz_window_sprite_decompressor.sv
src/lzsd_checker.sv
bench/lz_window_sprite_decompressor_tb.sv
